[src/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared constants, register indexes and the arctangent table of the
// go-to-goal proportional controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // Field widths.
   localparam int POS_W    = 16;
   localparam int HEAD_W   = 15;
   localparam int GAIN_W   = 12;
   localparam int STOP_W   = 15;
   localparam int LIN_W    = 15;
   localparam int ANG_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Parameter defaults.
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int TABLE_LEN         = 24;

   // CORDIC datapath widths.
   localparam int DIFF_W  = POS_W + 1;
   localparam int GUARD   = 14;
   localparam int XY_W    = 34;
   localparam int Z_W     = 35;
   localparam int BEAR_W  = 17;
   localparam int ERR_W   = BEAR_W + 1;
   localparam int DIST_W  = 20;
   localparam int INV_W   = 30;
   localparam int ANGLE_FRAC = 12;

   localparam logic [Z_W-1:0]   PI_Q30       = 35'd3373259426;
   localparam logic [INV_W-1:0] INV_GAIN_Q30 = 30'd652032874;

   // Reset values of the configuration registers.
   localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 12'd51;
   localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 12'd768;
   localparam logic [STOP_W-1:0] STOP_RST     = 15'd10;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GOAL_X        = 3'd0,
      REG_GOAL_Y        = 3'd1,
      REG_LINEAR_GAIN   = 3'd2,
      REG_ANGULAR_GAIN  = 3'd3,
      REG_STOP_DISTANCE = 3'd4
   } reg_index_type;

   // Truncated arctangent of 2^-i in units of 2^-30 rad.
   function automatic logic [INV_W-1:0] atan_q30(input logic [4:0] idx);
      logic [INV_W-1:0] val;
      case (idx)
         5'd0:  val = 30'd843314856;
         5'd1:  val = 30'd497837829;
         5'd2:  val = 30'd263043836;
         5'd3:  val = 30'd133525158;
         5'd4:  val = 30'd67021686;
         5'd5:  val = 30'd33543515;
         5'd6:  val = 30'd16775850;
         5'd7:  val = 30'd8388437;
         5'd8:  val = 30'd4194282;
         5'd9:  val = 30'd2097149;
         5'd10: val = 30'd1048575;
         5'd11: val = 30'd524287;
         5'd12: val = 30'd262143;
         5'd13: val = 30'd131071;
         5'd14: val = 30'd65535;
         5'd15: val = 30'd32767;
         5'd16: val = 30'd16383;
         5'd17: val = 30'd8191;
         5'd18: val = 30'd4095;
         5'd19: val = 30'd2047;
         5'd20: val = 30'd1023;
         5'd21: val = 30'd511;
         5'd22: val = 30'd255;
         5'd23: val = 30'd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[src/gtg_if.sv]
// ----------------------------------------------------------------------------
// gtg_if
// Channel interfaces for pose samples, speed commands and register writes.
// ----------------------------------------------------------------------------
interface gtg_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gtg_pkg::POS_W-1:0]      pos_x;
   logic signed [gtg_pkg::POS_W-1:0]      pos_y;
   logic signed [gtg_pkg::HEAD_W-1:0]     heading;
   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [gtg_pkg::LIN_W-1:0]             linear_speed;
   logic signed [gtg_pkg::ANG_W-1:0]      angular_speed;
   logic                                  is_stop;
   logic                                  last;
   modport source (output valid, linear_speed, angular_speed, is_stop, last, input ready);
   modport sink   (input valid, linear_speed, angular_speed, is_stop, last, output ready);
endinterface

interface gtg_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [gtg_pkg::CSR_IDX_W-1:0]         index;
   logic [gtg_pkg::CSR_DAT_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/go_to_goal_proportional_controller_core.sv]
// ----------------------------------------------------------------------------
// go_to_goal_proportional_controller_core
// Go-to-goal proportional controller for a unicycle robot.
// ----------------------------------------------------------------------------
// The first command of a pose transaction is worked out in turn by the CORDIC,
// one rotation per cycle; the gain-removal multiply, one bit of its 30-bit
// constant per cycle; and the two speed multiplies, one gain bit per cycle,
// run in parallel. Start pulses and done flags between the units are
// registered. A new pose is taken only after the receiver has accepted the
// last command of the previous one, which is the stop command when it
// follows. One pose is worked on at a time; a sample arriving after the goal
// was reached is taken and dropped. Register writes are always accepted.
// ----------------------------------------------------------------------------
module go_to_goal_proportional_controller_core #(
   parameter int CORDIC_STEPS  = gtg_pkg::CORDIC_STEPS_DEF,
   parameter int FRACTION_BITS = gtg_pkg::FRACTION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gtg_req_if.sink   req_ch,
   gtg_rsp_if.source rsp_ch,
   gtg_csr_if.sink   csr_ch
);

   localparam int DIFF_W = gtg_pkg::DIFF_W;
   localparam int XY_W   = gtg_pkg::XY_W;
   localparam int INV_W  = gtg_pkg::INV_W;
   localparam int DIST_W = gtg_pkg::DIST_W;
   localparam int GAIN_W = gtg_pkg::GAIN_W;
   localparam int ERR_W  = gtg_pkg::ERR_W;
   localparam int LP_W   = DIST_W + 1 + GAIN_W;
   localparam int AP_W   = ERR_W + GAIN_W;
   localparam int DP_W   = XY_W + INV_W;
   localparam int LIN_W  = gtg_pkg::LIN_W;
   localparam int ANG_W  = gtg_pkg::ANG_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CORDIC, S_SCALE, S_GAIN, S_MOVE, S_STOP
   } state_type;

   // Configuration registers.
   logic signed [gtg_pkg::POS_W-1:0] goal_x_ff, goal_y_ff;
   logic [GAIN_W-1:0]                lin_gain_ff, ang_gain_ff;
   logic [gtg_pkg::STOP_W-1:0]       stop_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         lin_gain_ff <= gtg_pkg::LIN_GAIN_RST;
         ang_gain_ff <= gtg_pkg::ANG_GAIN_RST;
         stop_ff     <= gtg_pkg::STOP_RST;
      end else if (csr_ch.valid) begin
         case (gtg_pkg::reg_index_type'(csr_ch.index))
            gtg_pkg::REG_GOAL_X:        goal_x_ff   <= csr_ch.data;
            gtg_pkg::REG_GOAL_Y:        goal_y_ff   <= csr_ch.data;
            gtg_pkg::REG_LINEAR_GAIN:   lin_gain_ff <= csr_ch.data[GAIN_W-1:0];
            gtg_pkg::REG_ANGULAR_GAIN:  ang_gain_ff <= csr_ch.data[GAIN_W-1:0];
            gtg_pkg::REG_STOP_DISTANCE: stop_ff     <= csr_ch.data[gtg_pkg::STOP_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath units.
   state_type                       state_ff;
   logic                            reached_ff;
   logic                            cordic_go_ff, scale_go_ff, gain_go_ff;
   logic signed [DIFF_W-1:0]        dx_ff, dy_ff;
   logic signed [gtg_pkg::HEAD_W-1:0] head_ff;
   logic                            cordic_done, scale_done, lin_done, ang_done;
   logic signed [XY_W-1:0]          mag;
   logic signed [gtg_pkg::BEAR_W-1:0] bearing;
   logic signed [gtg_pkg::BEAR_W-1:0] bear_ff;
   logic signed [DP_W-1:0]          dprod;
   logic [DP_W-1:0]                 dround;
   logic [DIST_W-1:0]               dist_ff;
   logic signed [LP_W-1:0]          lprod;
   logic signed [AP_W-1:0]          aprod;
   logic signed [ERR_W-1:0]         err;
   logic [LP_W:0]                   lround;
   logic signed [AP_W:0]            around;
   logic [LIN_W-1:0]                lin_sat;
   logic signed [ANG_W-1:0]         ang_sat;

   gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_go_ff),
      .dx(dx_ff), .dy(dy_ff), .done(cordic_done), .mag(mag), .bearing(bearing)
   );

   gtg_sermul #(.AW(XY_W), .BW(INV_W)) u_scale (
      .clock(clock), .reset(reset), .start(scale_go_ff), .a(mag),
      .b(gtg_pkg::INV_GAIN_Q30), .done(scale_done), .product(dprod)
   );

   gtg_sermul #(.AW(DIST_W + 1), .BW(GAIN_W)) u_lin (
      .clock(clock), .reset(reset), .start(gain_go_ff), .a({1'b0, dist_ff}),
      .b(lin_gain_ff), .done(lin_done), .product(lprod)
   );

   assign err = ERR_W'(bear_ff) - ERR_W'(head_ff);

   gtg_sermul #(.AW(ERR_W), .BW(GAIN_W)) u_ang (
      .clock(clock), .reset(reset), .start(gain_go_ff), .a(err),
      .b(ang_gain_ff), .done(ang_done), .product(aprod)
   );

   // Rounding and saturation of the results.
   always_comb begin
      dround = DP_W'(dprod) + (DP_W'(1) << (29 + gtg_pkg::GUARD));
      lround = ((LP_W + 1)'(lprod) + ((LP_W + 1)'(1) << (FRACTION_BITS - 1)))
               >> FRACTION_BITS;
      around = ((AP_W + 1)'(aprod) + ((AP_W + 1)'(1) <<< (gtg_pkg::ANGLE_FRAC - 1)))
               >>> gtg_pkg::ANGLE_FRAC;
      lin_sat = (lround > (LP_W + 1)'({LIN_W{1'b1}})) ? {LIN_W{1'b1}}
                                                      : lround[LIN_W-1:0];
      if (around > (AP_W + 1)'(32767)) begin
         ang_sat = ANG_W'(32767);
      end else if (around < -(AP_W + 1)'(32768)) begin
         ang_sat = {1'b1, {(ANG_W - 1){1'b0}}};
      end else begin
         ang_sat = around[ANG_W-1:0];
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         reached_ff    <= 1'b0;
         cordic_go_ff  <= 1'b0;
         scale_go_ff   <= 1'b0;
         gain_go_ff    <= 1'b0;
         rsp_ch.valid  <= 1'b0;
      end else begin
         cordic_go_ff <= 1'b0;
         scale_go_ff  <= 1'b0;
         gain_go_ff   <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && !reached_ff) begin
                  dx_ff        <= DIFF_W'(goal_x_ff) - DIFF_W'(req_ch.pos_x);
                  dy_ff        <= DIFF_W'(goal_y_ff) - DIFF_W'(req_ch.pos_y);
                  head_ff      <= req_ch.heading;
                  cordic_go_ff <= 1'b1;
                  state_ff     <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (cordic_done) begin
                  bear_ff     <= bearing;
                  scale_go_ff <= 1'b1;
                  state_ff    <= S_SCALE;
               end
            end
            S_SCALE: begin
               if (scale_done) begin
                  dist_ff    <= dround[DP_W-1 -: DIST_W];
                  gain_go_ff <= 1'b1;
                  state_ff   <= S_GAIN;
               end
            end
            S_GAIN: begin
               if (lin_done && ang_done) begin
                  rsp_ch.valid         <= 1'b1;
                  rsp_ch.linear_speed  <= lin_sat;
                  rsp_ch.angular_speed <= ang_sat;
                  rsp_ch.is_stop       <= 1'b0;
                  rsp_ch.last          <= !(DIST_W'(stop_ff) >= dist_ff);
                  state_ff             <= S_MOVE;
               end
            end
            S_MOVE: begin
               if (rsp_ch.ready) begin
                  if (rsp_ch.last) begin
                     rsp_ch.valid <= 1'b0;
                     state_ff     <= S_IDLE;
                  end else begin
                     rsp_ch.linear_speed  <= '0;
                     rsp_ch.angular_speed <= '0;
                     rsp_ch.is_stop       <= 1'b1;
                     rsp_ch.last          <= 1'b1;
                     reached_ff           <= 1'b1;
                     state_ff             <= S_STOP;
                  end
               end
            end
            S_STOP: begin
               if (rsp_ch.ready) begin
                  rsp_ch.valid <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/gtg_sermul.sv]
// ----------------------------------------------------------------------------
// gtg_sermul
// Bit-serial multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, low product bits shifted into a register.
// ----------------------------------------------------------------------------
module gtg_sermul #(
   parameter int AW = 18,
   parameter int BW = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [AW-1:0]  a,
   input  logic [BW-1:0]         b,
   output logic                  done,
   output logic signed [AW+BW-1:0] product
);

   localparam int CW = $clog2(BW + 1);

   logic signed [AW-1:0] a_ff;
   logic [BW-1:0]        b_ff, b_in;
   logic signed [AW:0]   acc_ff, acc_in;
   logic [BW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [AW:0]   addend, sum;

   // One add and shift per multiplier bit.
   always_comb begin
      addend  = b_ff[0] ? {a_ff[AW-1], a_ff} : '0;
      sum     = acc_ff + addend;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         lo_in   = '0;
         b_in    = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum[AW], sum[AW:1]};
         lo_in  = {sum[0], lo_ff[BW-1:1]};
         b_in   = {1'b0, b_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
      end
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {acc_ff[AW-1:0], lo_ff};

endmodule

[src/gtg_cordic.sv]
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative vectoring CORDIC: one rotation per cycle, giving the scaled
// magnitude and the bearing of the goal offset.
// ----------------------------------------------------------------------------
module gtg_cordic #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [gtg_pkg::DIFF_W-1:0]    dx,
   input  logic signed [gtg_pkg::DIFF_W-1:0]    dy,
   output logic                                 done,
   output logic signed [gtg_pkg::XY_W-1:0]      mag,
   output logic signed [gtg_pkg::BEAR_W-1:0]    bearing
);

   localparam int XY_W = gtg_pkg::XY_W;
   localparam int Z_W  = gtg_pkg::Z_W;
   localparam int NSTEP = (CORDIC_STEPS < gtg_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                             : gtg_pkg::TABLE_LEN;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, x0, y0;
   logic signed [Z_W-1:0]  z_ff, z_in, z0, zr;
   logic [4:0]             i_ff, i_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic                   zero_ff, zero_in;
   logic signed [Z_W-1:0]  at;

   // Start vector, folded into the right half plane.
   always_comb begin
      x0 = XY_W'(dx) <<< gtg_pkg::GUARD;
      y0 = XY_W'(dy) <<< gtg_pkg::GUARD;
      z0 = '0;
      if (dx < 0) begin
         x0 = -x0;
         y0 = -y0;
         z0 = (dy >= 0) ? gtg_pkg::PI_Q30 : -gtg_pkg::PI_Q30;
      end
   end

   // One micro-rotation per cycle.
   always_comb begin
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      at      = Z_W'(gtg_pkg::atan_q30(i_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
         i_in    = '0;
         busy_in = 1'b1;
         zero_in = (dx == 0) && (dy == 0);
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 5'(NSTEP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Round the angle half up to the output fraction.
   assign zr      = (z_ff + (Z_W'(1) <<< (29 - gtg_pkg::ANGLE_FRAC))) >>>
                    (30 - gtg_pkg::ANGLE_FRAC);
   assign bearing = zero_ff ? '0 : zr[gtg_pkg::BEAR_W-1:0];
   assign mag     = (x_ff < 0) ? '0 : x_ff;
   assign done    = done_ff;

endmodule
